// File: rtl/mbet_pkg.sv
`default_nettype none

package mbet_pkg;

	localparam int FRAC_BITS_DEF  = 28;
	localparam int INDEX_BITS_DEF = 12;
	localparam int COORD_W        = 32;
	localparam int COUNT_W        = 8;
	localparam int QUEUE_DEPTH    = 2;
	localparam int REG_ADDR_W     = 5;

	localparam logic [2:0] REG_X_ORIGIN    = 3'd0;
	localparam logic [2:0] REG_X_INCREMENT = 3'd1;
	localparam logic [2:0] REG_Y_ORIGIN    = 3'd2;
	localparam logic [2:0] REG_Y_INCREMENT = 3'd3;
	localparam logic [2:0] REG_ITER_LIMIT  = 3'd4;

	localparam logic signed [COORD_W-1:0] X_ORIGIN_RST    = -32'sd536870912;
	localparam logic signed [COORD_W-1:0] X_INCREMENT_RST = 32'sd524288;
	localparam logic signed [COORD_W-1:0] Y_ORIGIN_RST    = -32'sd536870912;
	localparam logic signed [COORD_W-1:0] Y_INCREMENT_RST = 32'sd524288;
	localparam logic [COUNT_W-1:0]        ITER_LIMIT_RST  = 8'd255;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x_origin;
		coord_t x_increment;
		coord_t y_origin;
		coord_t y_increment;
	} coord_cfg_t;

	// cr: real part (row coordinate), ci: imaginary part (column coordinate)
	typedef struct packed {
		coord_t cr;
		coord_t ci;
	} point_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_UPD
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/mbet_front.sv
`default_nettype none

module mbet_front import mbet_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [INDEX_BITS-1:0] column,
	input  wire logic [INDEX_BITS-1:0] row,
	input  wire coord_cfg_t            cfg,
	input  wire logic                  q_full,
	output logic                       busy,
	output logic                       push,
	output point_t                     push_data
);

	localparam int PROD_W = COORD_W + INDEX_BITS + 1;
	localparam int SUM_W  = PROD_W + 1;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7fff_ffff);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(32'sh8000_0000);

	logic                     accept;
	logic                     v_s1, v_s2;
	logic [INDEX_BITS-1:0]    col_s1, row_s1;
	logic signed [PROD_W-1:0] px, py;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic signed [SUM_W-1:0]  sx, sy;
	coord_t                   xc, yc;

	assign busy   = v_s1 | v_s2 | q_full;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	assign px = $signed(cfg.x_increment) * $signed({1'b0, col_s1});
	assign py = $signed(cfg.y_increment) * $signed({1'b0, row_s1});

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= column;
			row_s1 <= row;
		end
		if (v_s1) begin
			px_s2 <= px;
			py_s2 <= py;
		end
	end

	assign sx = SUM_W'(px_s2) + SUM_W'($signed(cfg.x_origin));
	assign sy = SUM_W'(py_s2) + SUM_W'($signed(cfg.y_origin));

	always_comb begin
		if (sx > SAT_HI) begin
			xc = 32'sh7fff_ffff;
		end else if (sx < SAT_LO) begin
			xc = 32'sh8000_0000;
		end else begin
			xc = sx[COORD_W-1:0];
		end
		if (sy > SAT_HI) begin
			yc = 32'sh7fff_ffff;
		end else if (sy < SAT_LO) begin
			yc = 32'sh8000_0000;
		end else begin
			yc = sy[COORD_W-1:0];
		end
	end

	assign push         = v_s2;
	assign push_data.cr = yc;
	assign push_data.ci = xc;

endmodule

`default_nettype wire

// File: rtl/mbet_queue.sv
`default_nettype none

module mbet_queue import mbet_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire point_t push_data,
	input  wire logic   pop,
	output logic        full,
	output logic        empty,
	output point_t      head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	point_t           entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/mbet_back.sv
`default_nettype none

module mbet_back import mbet_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire point_t             head,
	input  wire logic [COUNT_W-1:0] iteration_limit,
	output logic                    pop,
	output logic                    done,
	output logic [COUNT_W-1:0]      escape_count
);

	localparam logic [63:0] BOUND = 64'd4 << FRAC_BITS;

	back_state_t         state_q, state_d;
	logic                load, mul_en, step, finish;
	logic                done_q;
	logic [COUNT_W-1:0]  count_q, escape_count_q;
	coord_t              zr_q, zi_q, cr_q, ci_q;
	logic signed [63:0]  rr, ii, ri;
	logic signed [63:0]  rr_q, ii_q, ri_q;
	logic [63:0]         mag;
	logic                escape;
	logic signed [63:0]  diff, nr, ni;
	coord_t              nr_sat, ni_sat;

	function automatic coord_t sat32(input logic signed [63:0] v);
		coord_t r;
		if (v > 64'sh0000_0000_7fff_ffff) begin
			r = 32'sh7fff_ffff;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	assign rr = zr_q * zr_q;
	assign ii = zi_q * zi_q;
	assign ri = zr_q * zi_q;

	assign mag    = $unsigned(rr_q) + $unsigned(ii_q);
	assign escape = (mag >> FRAC_BITS) >= BOUND;
	assign diff   = rr_q - ii_q;
	assign nr     = (diff >>> FRAC_BITS) + 64'($signed(cr_q));
	assign ni     = (ri_q >>> (FRAC_BITS - 1)) + 64'($signed(ci_q));
	assign nr_sat = sat32(nr);
	assign ni_sat = sat32(ni);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (load) begin
				count_q <= '0;
			end else if (step) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		mul_en  = 1'b0;
		step    = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					load    = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				if (count_q >= iteration_limit) begin
					finish  = 1'b1;
					state_d = BK_IDLE;
				end else begin
					mul_en  = 1'b1;
					state_d = BK_UPD;
				end
			end
			BK_UPD: begin
				if (escape) begin
					finish  = 1'b1;
					state_d = BK_IDLE;
				end else begin
					step    = 1'b1;
					state_d = BK_MUL;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			zr_q <= '0;
			zi_q <= '0;
			cr_q <= head.cr;
			ci_q <= head.ci;
		end else if (step) begin
			zr_q <= nr_sat;
			zi_q <= ni_sat;
		end
		if (mul_en) begin
			rr_q <= rr;
			ii_q <= ii;
			ri_q <= ri;
		end
		if (finish) begin
			escape_count_q <= count_q;
		end
	end

	assign done         = done_q;
	assign escape_count = escape_count_q;

endmodule

`default_nettype wire

// File: rtl/mandelbrot_escape_time.sv
// Mandelbrot escape-time point unit, signed fixed point (Q4.28 by default).
// Configuration: APB-style port, five registers at byte addresses 0x00..0x10
// (x_origin, x_increment, y_origin, y_increment, iteration_limit). Write only
// while the block is idle. pready is tied high; reads return register values.
// Input: a beat (column, row) is taken when start is high and busy is low.
// Output: done pulses for one cycle with escape_count valid in that cycle.
// The receiver cannot stall; every result is presented exactly once.
// Front end: coordinate multiply and saturating add, one point in flight; it
// hands each point to a 2-entry queue and takes the next once the queue is not full.
// Back end: one shared complex square unit; each iteration is a product step,
// then an escape test and update. A point ends when it escapes or reaches
// iteration_limit, and only then does the back end pop the next point from
// the queue; this loop sets the rate.
// Reset clears the control state and loads the register reset values; no
// results are pending after reset.
`default_nettype none

module mandelbrot_escape_time import mbet_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [INDEX_BITS-1:0] column,
	input  wire logic [INDEX_BITS-1:0] row,
	output logic                       done,
	output logic [COUNT_W-1:0]         escape_count,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [REG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	coord_cfg_t         cfg_q;
	logic [COUNT_W-1:0] iteration_limit_q;
	logic               cfg_wr;
	logic [2:0]         reg_idx;
	logic               q_full, q_empty, push, pop;
	point_t             push_data, head;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin    <= X_ORIGIN_RST;
			cfg_q.x_increment <= X_INCREMENT_RST;
			cfg_q.y_origin    <= Y_ORIGIN_RST;
			cfg_q.y_increment <= Y_INCREMENT_RST;
			iteration_limit_q <= ITER_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_X_ORIGIN:    cfg_q.x_origin    <= pwdata;
				REG_X_INCREMENT: cfg_q.x_increment <= pwdata;
				REG_Y_ORIGIN:    cfg_q.y_origin    <= pwdata;
				REG_Y_INCREMENT: cfg_q.y_increment <= pwdata;
				REG_ITER_LIMIT:  iteration_limit_q <= pwdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_X_ORIGIN:    prdata = cfg_q.x_origin;
			REG_X_INCREMENT: prdata = cfg_q.x_increment;
			REG_Y_ORIGIN:    prdata = cfg_q.y_origin;
			REG_Y_INCREMENT: prdata = cfg_q.y_increment;
			REG_ITER_LIMIT:  prdata = {(32-COUNT_W)'(0), iteration_limit_q};
			default:         prdata = '0;
		endcase
	end

	mbet_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.column   (column),
		.row      (row),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.busy     (busy),
		.push     (push),
		.push_data(push_data)
	);

	mbet_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	mbet_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.head           (head),
		.iteration_limit(iteration_limit_q),
		.pop            (pop),
		.done           (done),
		.escape_count   (escape_count)
	);

endmodule

`default_nettype wire

// File: rtl/mbet_checker.sv
`default_nettype none

module mbet_checker import mbet_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	localparam int OUT_MAX = QUEUE_DEPTH + 2;
	localparam int OUT_W   = $clog2(OUT_MAX + 1) + 1;

	logic             accept;
	logic [OUT_W-1:0] outstanding_q;

	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (accept && !done) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (done && !accept) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("front end not busy after taking a beat");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (outstanding_q != '0))
		else $error("result without a pending point");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= OUT_W'(OUT_MAX))
		else $error("more points pending than the block can hold");

endmodule

bind mandelbrot_escape_time mbet_checker u_mbet_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);

`default_nettype wire

// File: tb/sv/mandelbrot_escape_time_test.sv
module mandelbrot_escape_time_test import mbet_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = INDEX_BITS_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int ONE = 1 << FRAC;
	localparam int RANDOM_PHASES = 20;
	localparam int POINTS_PER_PHASE = 47;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_WAIT = 600;
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] row;
	} grid_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [IDX_W-1:0] column = '0;
	logic [IDX_W-1:0] row = '0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [REG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy;
	logic done;
	logic [COUNT_W-1:0] escape_count;
	logic [31:0] prdata;
	logic pready;

	// shadow copy of the register file
	coord_t x_origin_q = X_ORIGIN_RST;
	coord_t x_increment_q = X_INCREMENT_RST;
	coord_t y_origin_q = Y_ORIGIN_RST;
	coord_t y_increment_q = Y_INCREMENT_RST;
	logic [COUNT_W-1:0] iter_limit_q = ITER_LIMIT_RST;

	grid_point_t point_queue[$];
	logic [COUNT_W-1:0] count_queue[$];
	logic taken = 1'b0;
	logic gaps_on = 1'b1;
	int gap_left = 0;
	int cycle_count = 0;
	int error_count = 0;

	mandelbrot_escape_time u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.column(column),
		.row(row),
		.done(done),
		.escape_count(escape_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint clamp32(input longint v);
		if (v > longint'(32'sh7FFFFFFF))
			return longint'(32'sh7FFFFFFF);
		if (v < -longint'(64'h80000000))
			return -longint'(64'h80000000);
		return v;
	endfunction

	function automatic logic [COUNT_W-1:0] escape_count_of(input logic [IDX_W-1:0] col,
			input logic [IDX_W-1:0] rw);
		longint ci, cr, zr, zi, sq_r, sq_i;
		logic [63:0] mag_r, mag_i, mag;
		int unsigned count;
		logic escaped;
		ci = clamp32(longint'(x_origin_q) + longint'(x_increment_q) * longint'(col));
		cr = clamp32(longint'(y_origin_q) + longint'(y_increment_q) * longint'(rw));
		zr = 0;
		zi = 0;
		count = 0;
		escaped = 1'b0;
		while (!escaped && count < iter_limit_q) begin
			sq_r = zr * zr;
			sq_i = zi * zi;
			mag_r = sq_r;
			mag_i = sq_i;
			mag = mag_r + mag_i;
			if ((mag >> FRAC) >= (64'd4 << FRAC)) begin
				escaped = 1'b1;
			end else begin
				sq_r = ((sq_r - sq_i) >>> FRAC) + cr;
				sq_i = ((zr * zi) >>> (FRAC - 1)) + ci;
				zr = clamp32(sq_r);
				zi = clamp32(sq_i);
				count++;
			end
		end
		return count[COUNT_W-1:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_point(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] rw);
		grid_point_t p;
		p.column = col;
		p.row = rw;
		point_queue.push_back(p);
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_X_ORIGIN: x_origin_q = value;
			REG_X_INCREMENT: x_increment_q = value;
			REG_Y_ORIGIN: y_origin_q = value;
			REG_Y_INCREMENT: y_increment_q = value;
			REG_ITER_LIMIT: iter_limit_q = value[COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] xo, input logic [31:0] xi,
			input logic [31:0] yo, input logic [31:0] yi, input logic [7:0] lim);
		logic [31:0] lim_word;
		lim_word = $urandom();
		lim_word[7:0] = lim;
		write_reg(REG_X_ORIGIN, xo);
		write_reg(REG_X_INCREMENT, xi);
		write_reg(REG_Y_ORIGIN, yo);
		write_reg(REG_Y_INCREMENT, yi);
		write_reg(REG_ITER_LIMIT, lim_word);
	endtask

	// wait for the block to go idle: nothing queued, nothing in flight
	task automatic settle();
		do
			@(posedge clk);
		while (point_queue.size() != 0 || start || count_queue.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic random_phase(input int n);
		int kind, lim_pick, span, step;
		logic [7:0] lim;
		logic [IDX_W-1:0] col, rw;
		kind = $urandom_range(0, 4);
		lim_pick = $urandom_range(0, 19);
		if (lim_pick < 5)
			lim = 8'd255;
		else if (lim_pick < 7)
			lim = 8'd1;
		else
			lim = 8'($urandom_range(2, 100));
		span = 16 << (2 * $urandom_range(0, 4));
		if (kind == 0) begin
			// noise: any register values, any limit
			write_all($urandom(), $urandom(), $urandom(), $urandom(),
				8'($urandom_range(0, 255)));
		end else begin
			// grid laid over the interesting part of the plane
			step = (3 * ONE) / span;
			step = step + $urandom_range(0, step / 8);
			write_all(-int'($urandom_range(ONE, 3 * ONE / 2)), step,
				-int'($urandom_range(2 * ONE, 5 * ONE / 2)), step + $urandom_range(0, 7), lim);
		end
		gaps_on = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				col = IDX_W'($urandom());
				rw = IDX_W'($urandom());
			end else begin
				col = IDX_W'($urandom_range(0, span - 1));
				rw = IDX_W'($urandom_range(0, span - 1));
			end
			add_point(col, rw);
		end
	endtask

	// driver: one beat per accepted start, gaps drawn after each beat
	always @(negedge clk) begin
		grid_point_t next_point;
		if (arst_n && (!start || taken)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (point_queue.size() != 0) begin
				next_point = point_queue.pop_front();
				column <= next_point.column;
				row <= next_point.row;
				start <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on accept, compare on done
	always @(posedge clk) begin
		logic [COUNT_W-1:0] want;
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			taken <= start && !busy;
			if (done) begin
				if (count_queue.size() == 0) begin
					$error("escape_count: expected none, actual %0d", escape_count);
					error_count++;
				end else begin
					want = count_queue.pop_front();
					if (escape_count !== want) begin
						$error("escape_count: expected %0d, actual %0d", want, escape_count);
						error_count++;
					end
				end
			end
			if (start && !busy)
				count_queue.push_back(escape_count_of(column, row));
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values, corners and alternating bit patterns
		gaps_on = 1'b1;
		add_point(12'd0, 12'd0);
		add_point(12'd4095, 12'd4095);
		add_point(12'd4095, 12'd0);
		add_point(12'd0, 12'd4095);
		add_point(12'hAAA, 12'h555);
		add_point(12'h555, 12'hAAA);
		add_point(12'd1024, 12'd1536);
		settle();

		// coordinates saturate high (imaginary) and low (real); zero limit
		write_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 8'd0);
		add_point(12'd4095, 12'd4095);
		add_point(12'd0, 12'd0);
		settle();

		// writes past the register list must leave the registers alone
		write_reg(REG_ITER_LIMIT, 32'd3);
		for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
			write_reg(i[2:0], $urandom());
		add_point(12'd4095, 12'd4095);
		add_point(12'd1, 12'd0);
		settle();

		// real axis: c = -2 on the boundary, -1.75 inside, 0.25 at the cusp
		gaps_on = 1'b0;
		write_all(32'd0, 32'd0, -2 * ONE, ONE / 4, 8'd255);
		add_point(12'd0, 12'd0);
		add_point(12'd0, 12'd1);
		add_point(12'd0, 12'd9);
		add_point(12'd5, 12'd9);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_phase(POINTS_PER_PHASE);
			settle();
		end

		repeat (DRAIN_WAIT) @(negedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
